// ===== sv/irs_pkg.sv =====
// shared types and constants for the image resampling scaler
// field widths, opcodes, register indexes and the sequencer state type
// no dependencies
`default_nettype none

package irs_pkg;

	localparam int COORD_W  = 12;
	localparam int SAMPLE_W = 16;
	localparam int STEP_W   = 21;
	localparam int DIM_W    = 9;
	localparam int NUM_CH   = 4;
	localparam int PIX_W    = SAMPLE_W * NUM_CH;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	localparam logic [1:0] REG_STEP   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_FOURCH = 2'd3;

	localparam logic [STEP_W-1:0] STEP_RESET   = 21'd65536;
	localparam logic [DIM_W-1:0]  WIDTH_RESET  = 9'd256;
	localparam logic [DIM_W-1:0]  HEIGHT_RESET = 9'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_IDX,
		ST_READ,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

// ===== sv/irs_frame_mem.sv =====
// single-port frame store, one pixel of four samples per entry
// registered read data; uses irs_pkg for the pixel width
`default_nettype none

module irs_frame_mem
	import irs_pkg::*;
#(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [PIX_W-1:0] wdata,
	output logic      [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[addr] <= wdata;
		end
		if (en && !we) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/image_resampling_scaler_top.sv =====
// image resampling scaler: frame store, nearest and bilinear resampling
// depends on irs_pkg and irs_frame_mem
// loads never raise busy; a request is busy through MUL, IDX, READ and DRAIN, with one
// frame store read for nearest and four for bilinear (one per neighbour), result strobe
// in the first cycle with busy low; the next item can be taken in that same cycle
// reset clears the sequencer, the strobe and the registers; the frame store is not cleared
// results cannot be stalled: done lasts exactly one cycle
`default_nettype none

module image_resampling_scaler_top
	import irs_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// item channel
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                opcode,
	input  wire logic [COORD_W-1:0]  coord_x,
	input  wire logic [COORD_W-1:0]  coord_y,
	input  wire logic [SAMPLE_W-1:0] in_red,
	input  wire logic [SAMPLE_W-1:0] in_green,
	input  wire logic [SAMPLE_W-1:0] in_blue,
	input  wire logic [SAMPLE_W-1:0] in_green2,
	// result channel
	output logic                     done,
	output logic      [SAMPLE_W-1:0] out_red,
	output logic      [SAMPLE_W-1:0] out_green,
	output logic      [SAMPLE_W-1:0] out_blue,
	output logic      [SAMPLE_W-1:0] out_green2,
	output logic                     clamped,
	// register port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XI_W  = $clog2(MAX_WIDTH);
	localparam int YI_W  = $clog2(MAX_HEIGHT);
	localparam int PX_W  = COORD_W + STEP_W;       // coordinate times step
	localparam int IX_W  = PX_W - FRAC_BITS + 1;   // integer part plus rounding carry
	localparam int W_W   = FRAC_BITS + 1;          // weights reach exactly one
	localparam int PR_W  = SAMPLE_W + W_W;
	localparam int ACC_W = PR_W + 2;               // sum of four products
	localparam int SH_W  = ACC_W - FRAC_BITS;

	localparam logic [STEP_W-1:0]    STEP_ONE   = STEP_W'(1) << FRAC_BITS;
	localparam logic [W_W-1:0]       W_ONE      = W_W'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] HALF       = FRAC_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [AW-1:0]        ROW_STRIDE = AW'(MAX_WIDTH);
	localparam logic [IX_W-1:0]      MAXW_X     = IX_W'(MAX_WIDTH);
	localparam logic [IX_W-1:0]      MAXH_X     = IX_W'(MAX_HEIGHT);

	// ---------------------------------------------------------------- registers
	logic [STEP_W-1:0] step_q;
	logic [DIM_W-1:0]  src_w_q;
	logic [DIM_W-1:0]  src_h_q;
	logic              four_q;
	logic              cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RESET;
			src_w_q <= WIDTH_RESET;
			src_h_q <= HEIGHT_RESET;
			four_q  <= 1'b1;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_STEP:   step_q  <= pwdata[STEP_W-1:0];
				REG_WIDTH:  src_w_q <= pwdata[DIM_W-1:0];
				REG_HEIGHT: src_h_q <= pwdata[DIM_W-1:0];
				REG_FOURCH: four_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_STEP:   prdata = 32'(step_q);
			REG_WIDTH:  prdata = 32'(src_w_q);
			REG_HEIGHT: prdata = 32'(src_h_q);
			REG_FOURCH: prdata = 32'(four_q);
			default:    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	state_t state_q, state_d;
	logic [1:0] k_q;            // neighbour counter: bit 0 picks right, bit 1 picks lower
	logic       up_q;           // upscale, bilinear path
	logic       last_rd;
	logic       accept;
	logic       accept_load;
	logic       load_in_range;
	logic       rd_issue;

	assign accept        = start && !busy;
	assign load_in_range = ({1'b0, coord_x} < (COORD_W + 1)'(MAX_WIDTH))
	                    && ({1'b0, coord_y} < (COORD_W + 1)'(MAX_HEIGHT));
	assign last_rd       = !up_q || (k_q == 2'd3);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && opcode == OP_REQUEST) state_d = ST_MUL;
			ST_MUL:   state_d = ST_IDX;
			ST_IDX:   state_d = ST_READ;
			ST_READ:  if (last_rd) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b1;
		accept_load = 1'b0;
		rd_issue    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				accept_load = start && (opcode == OP_LOAD) && load_in_range;
			end
			ST_READ: rd_issue = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDX) begin
				k_q <= '0;
			end else if (state_q == ST_READ) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	// ---------------------------------------------------------------- coordinate maths
	logic [COORD_W-1:0] cx_q, cy_q;
	logic [PX_W-1:0]    px_q, py_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			cx_q <= coord_x;
			cy_q <= coord_y;
		end
		if (state_q == ST_MUL) begin
			px_q <= PX_W'(cx_q) * PX_W'(step_q);
			py_q <= PX_W'(cy_q) * PX_W'(step_q);
		end
	end

	// effective image size: zero counts as one, capped at the store size
	logic [IX_W-1:0] lim_w, lim_h;
	always_comb begin
		if (src_w_q == '0)                  lim_w = IX_W'(1);
		else if (IX_W'(src_w_q) > MAXW_X)   lim_w = MAXW_X;
		else                                lim_w = IX_W'(src_w_q);
		if (src_h_q == '0)                  lim_h = IX_W'(1);
		else if (IX_W'(src_h_q) > MAXH_X)   lim_h = MAXH_X;
		else                                lim_h = IX_W'(src_h_q);
	end

	logic                 up_d;
	logic [FRAC_BITS-1:0] fx_d, fy_d;
	logic [IX_W-1:0]      ix_t, ix_n, iy_t;
	logic                 rnd;
	logic                 x_clip, y_clip;
	logic [IX_W-1:0]      x1e, x2e, y1e, y2e;

	always_comb begin
		up_d = step_q < STEP_ONE;
		fx_d = px_q[FRAC_BITS-1:0];
		fy_d = py_q[FRAC_BITS-1:0];
		ix_t = IX_W'(px_q[PX_W-1:FRAC_BITS]);
		iy_t = IX_W'(py_q[PX_W-1:FRAC_BITS]);
		// nearest x rounds half to even; y and the bilinear origin truncate
		rnd  = !up_d && ((fx_d > HALF) || ((fx_d == HALF) && ix_t[0]));
		ix_n = ix_t + IX_W'(rnd);

		x_clip = ix_n >= lim_w;
		x1e    = x_clip ? (lim_w - IX_W'(1)) : ix_n;
		x2e    = ((x1e + IX_W'(1)) >= lim_w) ? (lim_w - IX_W'(1)) : (x1e + IX_W'(1));
		y_clip = iy_t >= lim_h;
		y1e    = y_clip ? (lim_h - IX_W'(1)) : iy_t;
		y2e    = ((y1e + IX_W'(1)) >= lim_h) ? (lim_h - IX_W'(1)) : (y1e + IX_W'(1));
	end

	logic [XI_W-1:0]      x1_q, x2_q;
	logic [YI_W-1:0]      y1_q, y2_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q;
	logic                 clamp_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDX) begin
			x1_q    <= XI_W'(x1e);
			x2_q    <= XI_W'(x2e);
			y1_q    <= YI_W'(y1e);
			y2_q    <= YI_W'(y2e);
			fx_q    <= fx_d;
			fy_q    <= fy_d;
			up_q    <= up_d;
			clamp_q <= x_clip || y_clip;
		end
	end

	// ---------------------------------------------------------------- frame store access
	logic [XI_W-1:0]  rx;
	logic [YI_W-1:0]  ry;
	logic [AW-1:0]    rd_addr, ld_addr, mem_addr;
	logic [PIX_W-1:0] mem_rdata;

	assign rx       = k_q[0] ? x2_q : x1_q;
	assign ry       = k_q[1] ? y2_q : y1_q;
	assign rd_addr  = AW'(ry) * ROW_STRIDE + AW'(rx);
	assign ld_addr  = AW'(coord_y) * ROW_STRIDE + AW'(coord_x);
	assign mem_addr = rd_issue ? rd_addr : ld_addr;

	irs_frame_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.en   (accept_load || rd_issue),
		.we   (accept_load),
		.addr (mem_addr),
		.wdata({in_green2, in_blue, in_green, in_red}),
		.rdata(mem_rdata)
	);

	// ---------------------------------------------------------------- weights and accumulation
	// the weight of each neighbour is formed while its read is in flight
	logic [W_W-1:0]   wa, wb;
	logic [2*W_W-1:0] wprod;
	logic [W_W-1:0]   weight_s1;
	logic             mac_s1;

	assign wa    = k_q[0] ? {1'b0, fx_q} : (W_ONE - {1'b0, fx_q});
	assign wb    = k_q[1] ? {1'b0, fy_q} : (W_ONE - {1'b0, fy_q});
	assign wprod = wa * wb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
		end else begin
			mac_s1 <= rd_issue && up_q;
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= wprod[2*FRAC_BITS:FRAC_BITS];
	end

	logic [ACC_W-1:0] acc_q [NUM_CH];
	logic [ACC_W-1:0] acc_n [NUM_CH];
	logic [PR_W-1:0]  prod  [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod[c]  = PR_W'(mem_rdata[c*SAMPLE_W +: SAMPLE_W]) * PR_W'(weight_s1);
			acc_n[c] = mac_s1 ? (acc_q[c] + ACC_W'(prod[c])) : acc_q[c];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (state_q == ST_IDX) begin
				acc_q[c] <= '0;
			end else begin
				acc_q[c] <= acc_n[c];
			end
		end
	end

	// ---------------------------------------------------------------- result beat
	logic [SAMPLE_W-1:0] res   [NUM_CH];
	logic [SH_W-1:0]     sumsh [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sumsh[c] = acc_n[c][ACC_W-1:FRAC_BITS];
			if (up_q) begin
				res[c] = (sumsh[c] > SH_W'({SAMPLE_W{1'b1}})) ? {SAMPLE_W{1'b1}}
				                                              : sumsh[c][SAMPLE_W-1:0];
			end else begin
				res[c] = mem_rdata[c*SAMPLE_W +: SAMPLE_W];
			end
		end
		// three-channel nearest copy leaves the second green at zero
		if (!up_q && !four_q) begin
			res[3] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_DRAIN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			out_red    <= res[0];
			out_green  <= res[1];
			out_blue   <= res[2];
			out_green2 <= res[3];
			clamped    <= clamp_q;
		end
	end

endmodule

`default_nettype wire

// ===== sim/image_resampling_scaler_top_tb.sv =====
// self-checking testbench for the image resampling scaler: item beats, register writes and
// a bit-accurate predictor of every result pixel, compared field by field as results arrive
// depends on irs_pkg and image_resampling_scaler_top

module image_resampling_scaler_top_tb
	import irs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// block geometry, matched to the instance below
	localparam int MAX_W = 256;
	localparam int MAX_H = 256;
	localparam int FRAC  = 16;
	localparam longint unsigned FX_ONE = 64'd1 << FRAC;

	// cycles without any accepted beat before the run is declared hung
	localparam int STALL_LIMIT   = 500;
	// quiet cycles after the last result, covers a trailing load still in flight
	localparam int SETTLE_CYCLES = 12;
	// side of the square of source pixels loaded at the start of each phase
	localparam int FILL_EDGE     = 6;

	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] pixel_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
		logic [SAMPLE_W-1:0] green2;
		logic                clamped;
	} pixel_result_t;

	// every block input has a known value from time zero
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                opcode    = OP_LOAD;
	logic [COORD_W-1:0]  coord_x   = '0;
	logic [COORD_W-1:0]  coord_y   = '0;
	logic [SAMPLE_W-1:0] in_red    = '0;
	logic [SAMPLE_W-1:0] in_green  = '0;
	logic [SAMPLE_W-1:0] in_blue   = '0;
	logic [SAMPLE_W-1:0] in_green2 = '0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [3:0]          paddr     = '0;
	logic [31:0]         pwdata    = '0;
	logic                busy;
	logic                done;
	logic [SAMPLE_W-1:0] out_red;
	logic [SAMPLE_W-1:0] out_green;
	logic [SAMPLE_W-1:0] out_blue;
	logic [SAMPLE_W-1:0] out_green2;
	logic                clamped;
	logic [31:0]         prdata;
	logic                pready;

	// predictor state: our own copy of the frame store and the registers
	pixel_t            pixel_mem   [MAX_W*MAX_H];
	bit                pixel_known [MAX_W*MAX_H];
	logic [STEP_W-1:0] step_reg    = STEP_RESET;
	logic [DIM_W-1:0]  width_reg   = WIDTH_RESET;
	logic [DIM_W-1:0]  height_reg  = HEIGHT_RESET;
	logic              fourch_reg  = 1'b1;

	// result pixels predicted but not yet seen on the result port, oldest first
	pixel_result_t expected_pixels[$];

	int errors       = 0;
	int stall_cycles = 0;
	// set for phases that run with no sender idling at all
	bit no_idle      = 1'b0;

	always #10 clk = ~clk;

	image_resampling_scaler_top #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H),
		.FRAC_BITS (FRAC)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.in_green2 (in_green2),
		.done      (done),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_green2(out_green2),
		.clamped   (clamped),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// ---------------------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------------------

	// a dimension of zero behaves as one, anything above the store size as the maximum
	function automatic int unsigned dim_limit(input logic [DIM_W-1:0] v, input int unsigned maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic int unsigned clamp_idx(input longint unsigned idx, input int unsigned dim);
		return (idx >= dim) ? dim - 1 : int'(idx);
	endfunction

	// loads beyond the store are dropped, no wrap onto lower rows or columns
	function automatic void store_pixel(input logic [COORD_W-1:0] x, y, input pixel_t samples);
		int unsigned a;
		if (x < MAX_W && y < MAX_H) begin
			a = y * MAX_W + x;
			pixel_mem[a]   = samples;
			pixel_known[a] = 1'b1;
		end
	endfunction

	// expected pixel for an output coordinate; returns 0 if any source read would land on
	// a store entry that was never loaded, so the stimulus can steer clear of it
	function automatic bit resample_pixel(input logic [COORD_W-1:0] x, y,
			output pixel_result_t res);
		longint unsigned px, py, ix, iy, fx, fy, w11, w12, w21, w22, acc;
		int unsigned     w, h, sx, sy, x2, y2, a11, a12, a21, a22;
		pixel_t          chan;
		bit              known;
		px = 64'(x) * 64'(step_reg);
		py = 64'(y) * 64'(step_reg);
		w  = dim_limit(width_reg, MAX_W);
		h  = dim_limit(height_reg, MAX_H);
		ix = px >> FRAC;
		iy = py >> FRAC;
		fx = px & (FX_ONE - 1);
		fy = py & (FX_ONE - 1);
		if (step_reg >= FX_ONE) begin
			// copy or downscale: nearest column rounded half to even, row truncated
			if (fx > FX_ONE / 2 || (fx == FX_ONE / 2 && ix[0]))
				ix = ix + 1;
			sx    = clamp_idx(ix, w);
			sy    = clamp_idx(iy, h);
			a11   = sy * MAX_W + sx;
			known = pixel_known[a11];
			chan  = pixel_mem[a11];
			if (!fourch_reg)
				chan[3] = '0;
		end else begin
			// upscale: bilinear over all four channels, right and lower neighbours held
			// at the last column and row without flagging it
			sx  = clamp_idx(ix, w);
			sy  = clamp_idx(iy, h);
			x2  = clamp_idx(64'(sx) + 1, w);
			y2  = clamp_idx(64'(sy) + 1, h);
			w11 = ((FX_ONE - fx) * (FX_ONE - fy)) >> FRAC;
			w12 = ((FX_ONE - fx) * fy) >> FRAC;
			w21 = (fx * (FX_ONE - fy)) >> FRAC;
			w22 = (fx * fy) >> FRAC;
			a11 = sy * MAX_W + sx;
			a12 = y2 * MAX_W + sx;
			a21 = sy * MAX_W + x2;
			a22 = y2 * MAX_W + x2;
			known = pixel_known[a11] && pixel_known[a12] && pixel_known[a21] && pixel_known[a22];
			for (int c = 0; c < NUM_CH; c++) begin
				acc = 64'(pixel_mem[a11][c]) * w11 + 64'(pixel_mem[a21][c]) * w21
				    + 64'(pixel_mem[a12][c]) * w12 + 64'(pixel_mem[a22][c]) * w22;
				acc = acc >> FRAC;
				chan[c] = (acc > 64'hFFFF) ? 16'hFFFF : acc[SAMPLE_W-1:0];
			end
		end
		res.red     = chan[0];
		res.green   = chan[1];
		res.blue    = chan[2];
		res.green2  = chan[3];
		// only the nearest or top-left index counts as clamping
		res.clamped = (ix >= w) || (iy >= h);
		return known;
	endfunction

	function automatic logic [31:0] register_field(input logic [1:0] idx, input logic [31:0] v);
		case (idx)
			REG_STEP:   return 32'(v[STEP_W-1:0]);
			REG_WIDTH:  return 32'(v[DIM_W-1:0]);
			REG_HEIGHT: return 32'(v[DIM_W-1:0]);
			default:    return 32'(v[0]);
		endcase
	endfunction

	// ---------------------------------------------------------------------------------
	// result checking and watchdog
	// ---------------------------------------------------------------------------------

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
			errors++;
		end
	endtask

	// a result beat is taken at the edge that ends its strobe cycle
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h %h %h %h %b", $time,
					out_red, out_green, out_blue, out_green2, clamped);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("out_red", want.red, out_red);
				check_field("out_green", want.green, out_green);
				check_field("out_blue", want.blue, out_blue);
				check_field("out_green2", want.green2, out_green2);
				check_field("clamped", want.clamped, clamped);
			end
		end
	end

	// any item beat, result beat or register access counts as progress
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start && busy === 1'b0) || done === 1'b1 || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[image_resampling_scaler_top] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------------------
	// item channel
	// ---------------------------------------------------------------------------------

	// one item beat: optional idle gap, then start held until the edge with busy low;
	// with no gap start stays high and only the payload moves on
	task automatic send_item(input logic op, input logic [COORD_W-1:0] x, y, input pixel_t samples);
		int            gap;
		pixel_result_t want;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start     <= 1'b1;
		opcode    <= op;
		coord_x   <= x;
		coord_y   <= y;
		in_red    <= samples[0];
		in_green  <= samples[1];
		in_blue   <= samples[2];
		in_green2 <= samples[3];
		do @(posedge clk); while (busy !== 1'b0);
		if (op == OP_LOAD) begin
			store_pixel(x, y, samples);
		end else begin
			void'(resample_pixel(x, y, want));
			expected_pixels.push_back(want);
		end
	endtask

	// samples lean towards full scale now and then, to stress the weighted sum
	function automatic pixel_t random_samples();
		pixel_t s;
		for (int c = 0; c < NUM_CH; c++)
			s[c] = ($urandom_range(0, 7) == 0) ? '1 : SAMPLE_W'($urandom);
		return s;
	endfunction

	// requests carry random samples, which the block must ignore
	task automatic send_request(input logic [COORD_W-1:0] x, y);
		send_item(OP_REQUEST, x, y, random_samples());
	endtask

	// stop issuing, wait for every outstanding result, then let the block go quiet
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ---------------------------------------------------------------------------------
	// register port
	// ---------------------------------------------------------------------------------

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
		logic [31:0] got;
		apb_access(1'b0, idx, $urandom, got);
		check_field("register readback", want, got);
	endtask

	// writes only ever happen with the block idle
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] unused;
		drain_results();
		apb_access(1'b1, idx, value, unused);
		case (idx)
			REG_STEP:   step_reg   = value[STEP_W-1:0];
			REG_WIDTH:  width_reg  = value[DIM_W-1:0];
			REG_HEIGHT: height_reg = value[DIM_W-1:0];
			REG_FOURCH: fourch_reg = value[0];
			default:    ;
		endcase
		check_register(idx, register_field(idx, value));
	endtask

	// ---------------------------------------------------------------------------------
	// stimulus helpers for the random phases
	// ---------------------------------------------------------------------------------

	function automatic int unsigned loaded_extent(input logic [DIM_W-1:0] v, input int unsigned maxv);
		int unsigned d;
		d = dim_limit(v, maxv);
		return (d < FILL_EDGE) ? d : FILL_EDGE;
	endfunction

	// largest output coordinate whose source position stays within the loaded extent plus one, capped at 4095
	function automatic int unsigned coord_reach(input int unsigned extent);
		longint unsigned r;
		if (step_reg == 0)
			return 4095;
		r = ((64'(extent) + 1) << FRAC) / step_reg;
		return (r > 4095) ? 4095 : int'(r);
	endfunction

	// top-left square plus last column, last row and the bottom-right corner, so that
	// clamped and corner reads find loaded pixels too
	task automatic load_frame_region();
		int unsigned w, h, fw, fh;
		w  = dim_limit(width_reg, MAX_W);
		h  = dim_limit(height_reg, MAX_H);
		fw = loaded_extent(width_reg, MAX_W);
		fh = loaded_extent(height_reg, MAX_H);
		for (int unsigned y = 0; y < fh; y++)
			for (int unsigned x = 0; x < fw; x++)
				send_item(OP_LOAD, COORD_W'(x), COORD_W'(y), random_samples());
		for (int unsigned i = 0; i < fh; i++)
			send_item(OP_LOAD, COORD_W'(w - 1), COORD_W'(i), random_samples());
		for (int unsigned i = 0; i < fw; i++)
			send_item(OP_LOAD, COORD_W'(i), COORD_W'(h - 1), random_samples());
		for (int unsigned i = 0; i < 4; i++)
			if (w > i % 2 && h > i / 2)
				send_item(OP_LOAD, COORD_W'(w - 1 - i % 2), COORD_W'(h - 1 - i / 2),
					random_samples());
	endtask

	// mostly coordinates that land in the loaded area, some anywhere in the 12-bit range;
	// candidates that would read a never-loaded pixel are redrawn
	task automatic send_random_request();
		logic [COORD_W-1:0] x, y;
		pixel_result_t      probe;
		int unsigned        reach_x, reach_y;
		reach_x = coord_reach(loaded_extent(width_reg, MAX_W));
		reach_y = coord_reach(loaded_extent(height_reg, MAX_H));
		for (int tries = 0; tries < 64; tries++) begin
			if ($urandom_range(0, 3) == 0) begin
				x = COORD_W'($urandom);
				y = COORD_W'($urandom);
			end else begin
				x = COORD_W'($urandom_range(0, reach_x));
				y = COORD_W'($urandom_range(0, reach_y));
			end
			if (resample_pixel(x, y, probe)) begin
				send_request(x, y);
				return;
			end
		end
		// nothing usable found: refresh the origin pixel instead
		send_item(OP_LOAD, '0, '0, random_samples());
	endtask

	task automatic run_random_items(input int count);
		int unsigned pick, w, fw, fh;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			w    = dim_limit(width_reg, MAX_W);
			fw   = loaded_extent(width_reg, MAX_W);
			fh   = loaded_extent(height_reg, MAX_H);
			if (pick < 6) begin
				send_random_request();
			end else if (pick < 9) begin
				// overwrite a loaded pixel, now and then one in the last column
				send_item(OP_LOAD,
					COORD_W'(($urandom_range(0, 3) == 0) ? w - 1 : $urandom_range(0, fw - 1)),
					COORD_W'($urandom_range(0, fh - 1)), random_samples());
			end else begin
				// noise load anywhere, most of it beyond the store and dropped
				send_item(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), random_samples());
			end
		end
	endtask

	// ---------------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------------

	task automatic test_register_defaults();
		check_register(REG_STEP, 32'(STEP_RESET));
		check_register(REG_WIDTH, 32'(WIDTH_RESET));
		check_register(REG_HEIGHT, 32'(HEIGHT_RESET));
		check_register(REG_FOURCH, 32'd1);
	endtask

	// short hand-picked sequence on a 2x2 image covering each mode and edge behaviour
	task automatic test_directed();
		write_register(REG_WIDTH, 32'd2);
		write_register(REG_HEIGHT, 32'd2);
		write_register(REG_STEP, 32'd65536);
		write_register(REG_FOURCH, 32'd1);
		// samples at both extremes
		send_item(OP_LOAD, 0, 0, '1);
		send_item(OP_LOAD, 1, 0, '0);
		send_item(OP_LOAD, 0, 1, {16'h4444, 16'h3333, 16'h2222, 16'h1111});
		send_item(OP_LOAD, 1, 1, random_samples());
		// loads beyond the store must be dropped, not aliased onto row or column zero
		send_item(OP_LOAD, 12'hFFF, 12'hFFF, {4{16'hA5A5}});
		send_item(OP_LOAD, 12'd256, 12'd0, {4{16'h5A5A}});
		send_item(OP_LOAD, 12'd0, 12'd256, {4{16'hC3C3}});
		// plain copy, including a request far beyond the image
		send_request(0, 0);
		send_request(1, 1);
		send_request(12'hFFF, 12'hFFF);
		send_request(1, 0);
		// three-channel copy zeroes the second green
		write_register(REG_FOURCH, 32'd0);
		send_request(0, 0);
		send_request(1, 1);
		// 2x upscale: exact pixel, half-way blend, corner neighbour, clamped top-left
		write_register(REG_STEP, 32'd32768);
		send_request(0, 0);
		send_request(1, 1);
		send_request(3, 3);
		send_request(12'hFFF, 0);
		// zero step always lands on the origin pixel
		write_register(REG_STEP, 32'd0);
		send_request(12'hFFF, 12'hFFF);
		// largest step, rounding pushes the column past the edge
		write_register(REG_STEP, 32'h1F_FFFF);
		send_request(1, 1);
		send_request(0, 0);
		// width of zero behaves as one column
		write_register(REG_STEP, 32'd65536);
		write_register(REG_WIDTH, 32'd0);
		send_request(1, 0);
	endtask

	// a run of phases, each with its own register setting, a fresh load and random items
	task automatic test_random_phases();
		logic [31:0] step_v, width_v, height_v, four_v;
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin step_v = 65536;      width_v = 256; height_v = 256; four_v = 1; end
				1: begin step_v = 1;          width_v = 1;   height_v = 1;   four_v = 0; end
				2: begin step_v = 1048576;    width_v = 16;  height_v = 16;  four_v = 1; end
				3: begin step_v = 32'h1FFFFF; width_v = 511; height_v = 0;   four_v = 0; end
				4: begin step_v = 65535;      width_v = 8;   height_v = 8;   four_v = 1; end
				// one and a half: exposes half-to-even rounding of the column
				5: begin step_v = 98304;      width_v = 8;   height_v = 5;   four_v = 0; end
				default: begin
					step_v   = $urandom_range(0, 1) ? $urandom_range(0, 65535)
					                                : $urandom_range(65536, 1048576);
					width_v  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
					                                       : $urandom_range(1, 8);
					height_v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
					                                       : $urandom_range(1, 8);
					four_v   = $urandom_range(0, 1);
					// junk above the register width must be ignored
					if ($urandom_range(0, 1)) begin
						step_v   = step_v | ($urandom & 32'hFFE0_0000);
						width_v  = width_v | ($urandom & 32'hFFFF_FE00);
						height_v = height_v | ($urandom & 32'hFFFF_FE00);
						four_v   = four_v | ($urandom & 32'hFFFF_FFFE);
					end
				end
			endcase
			write_register(REG_STEP, step_v);
			write_register(REG_WIDTH, width_v);
			write_register(REG_HEIGHT, height_v);
			write_register(REG_FOURCH, four_v);
			// every third phase back to back, the rest with random gaps
			no_idle = (phase % 3 == 2);
			load_frame_region();
			run_random_items(50);
		end
		no_idle = 1'b0;
	endtask

	// ---------------------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------------------

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_register_defaults();
		test_directed();
		test_random_phases();
		drain_results();
		if (errors == 0)
			$display("[image_resampling_scaler_top] OK");
		else
			$display("[image_resampling_scaler_top] ERROR");
		$finish;
	end

endmodule
